// ----- design/lsrd_pkg.sv -----
package lsrd_pkg;

    // Controller states of the top level.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_OUT
    } t_state;

    // Configuration register indexes.
    typedef logic [1:0] t_cfg_index;
    localparam t_cfg_index CFG_SAMPLES_PER_SECTOR = 2'd0;
    localparam t_cfg_index CFG_SECTOR_COUNT       = 2'd1;
    localparam t_cfg_index CFG_RANGE_MIN_MM       = 2'd2;
    localparam t_cfg_index CFG_RANGE_MAX_MM       = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [6:0]  RST_SAMPLES_PER_SECTOR = 7'd5;
    localparam logic [10:0] RST_SECTOR_COUNT       = 11'd72;
    localparam logic [15:0] RST_RANGE_MIN_MM       = 16'd20;
    localparam logic [15:0] RST_RANGE_MAX_MM       = 16'd12000;

    // Status of the serial divider as seen by its controller.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

    // Truncating division of a 16-bit value by ten. The reciprocal
    // 52429 / 2^19 is exact over the whole 16-bit range.
    function automatic logic [12:0] div10(input logic [15:0] x);
        logic [31:0] p;
        p = {16'd0, x} * 32'd52429;
        return p[31:19];
    endfunction

endpackage

// ----- design/lidar_sector_range_downsampler_core.sv -----
// Lidar sector range downsampler.
//
// Range samples enter on the s-side stream: tdata carries distance_mm,
// tuser the not-finite flag and tlast the end of a scan. Valid samples of
// each sector are averaged and one request per finished sector whose slot
// is below MAX_SECTORS leaves on the m-side stream: tdata carries slot and
// the sector range in cm, tuser has_data, and tlast marks the last sector.
// Registers are written through the cfg channel, which is always ready;
// write them only while the block is idle.
// Samples are taken while the controller is idle. A sample that closes an
// emitted sector starts the bit-serial divider, which works out one quotient
// bit per cycle over the width of the sector sum; the input stalls until
// the controller has passed through the division and output states, and
// the result is loaded into the output register from the output state.
// The output register parts the two sides: samples keep coming in while a
// result waits. If the receiver stalls, the next finished sector waits in
// the controller and the input stalls until the output register frees up.
// Synchronous reset restores the register defaults and clears all counters.
module lidar_sector_range_downsampler_core #(
    parameter int MAX_SECTORS            = 72,
    parameter int MAX_SAMPLES_PER_SECTOR = 64,
    localparam int SW   = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1,
    localparam int OTDW = ((SW + 16 + 7) / 8) * 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Sample stream.
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [15:0]                 i_s_tdata,   // [15:0] distance_mm
    input  logic                        i_s_tuser,   // [0] not_finite
    input  logic                        i_s_tlast,   // scan_end
    // Sector stream.
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [OTDW-1:0]             o_m_tdata,   // [SW-1:0] slot, [SW+15:SW] sector_cm
    output logic                        o_m_tuser,   // [0] has_data
    output logic                        o_m_tlast,   // final_sector
    // Configuration writes.
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  lsrd_pkg::t_cfg_index        i_cfg_index,
    input  logic [15:0]                 i_cfg_data
);
    import lsrd_pkg::*;

    localparam int VW   = $clog2(MAX_SAMPLES_PER_SECTOR + 1);
    localparam int SUMW = 16 + $clog2(MAX_SAMPLES_PER_SECTOR);
    localparam int DW   = $clog2(10 * MAX_SAMPLES_PER_SECTOR + 1);

    // Configuration registers and the window in centimeters.
    logic [6:0]  r_sps;
    logic [10:0] r_sec_count;
    logic [15:0] r_min_mm;
    logic [15:0] r_max_mm;
    logic [12:0] r_min_cm;
    logic [12:0] r_max_cm;

    // Scan counters.
    logic [SUMW-1:0] r_sum;
    logic [VW-1:0]   r_valid;
    logic [VW-1:0]   r_pos;
    logic [10:0]     r_sec_num;

    // Pending sector and output register.
    t_state          r_state;
    t_state          n_state;
    logic            r_empty;
    logic [SW-1:0]   r_slot;
    logic            r_final;
    logic            r_m_valid;
    logic [SW-1:0]   r_m_slot;
    logic [15:0]     r_m_dist;
    logic            r_m_has;
    logic            r_m_final;

    logic [VW-1:0]   sps_sat;
    logic            active;
    logic            in_win;
    logic [SUMW-1:0] sum_next;
    logic [VW-1:0]   valid_next;
    logic [VW-1:0]   pos_next;
    logic            finish;
    logic [10:0]     slot_full;
    logic            emit;
    logic            s_accept;
    logic            can_load;
    logic            load_out;
    logic [DW-1:0]   divisor;
    logic [SUMW-1:0] quotient;
    logic [SUMW-1:0] cm_value;
    logic [15:0]     cm_out;
    logic            has;
    t_div_status     div_status;

    assign o_cfg_ready = 1'b1;

    // Register writes; the centimeter window is worked out at write time.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sps       <= RST_SAMPLES_PER_SECTOR;
            r_sec_count <= RST_SECTOR_COUNT;
            r_min_mm    <= RST_RANGE_MIN_MM;
            r_max_mm    <= RST_RANGE_MAX_MM;
            r_min_cm    <= div10(RST_RANGE_MIN_MM);
            r_max_cm    <= div10(RST_RANGE_MAX_MM);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SAMPLES_PER_SECTOR: r_sps <= i_cfg_data[6:0];
                CFG_SECTOR_COUNT:       r_sec_count <= i_cfg_data[10:0];
                CFG_RANGE_MIN_MM: begin
                    r_min_mm <= i_cfg_data;
                    r_min_cm <= div10(i_cfg_data);
                end
                CFG_RANGE_MAX_MM: begin
                    r_max_mm <= i_cfg_data;
                    r_max_cm <= div10(i_cfg_data);
                end
                default: ;
            endcase
        end
    end

    // Sample qualification and next counter values.
    always_comb begin
        if (32'(r_sps) > MAX_SAMPLES_PER_SECTOR) begin
            sps_sat = VW'(MAX_SAMPLES_PER_SECTOR);
        end else begin
            sps_sat = VW'(r_sps);
        end
        active     = (sps_sat != '0) && (r_sec_num < r_sec_count);
        in_win     = !i_s_tuser && (i_s_tdata >= r_min_mm) && (i_s_tdata <= r_max_mm);
        sum_next   = r_sum + (in_win ? SUMW'(i_s_tdata) : SUMW'(0));
        valid_next = r_valid + VW'(in_win);
        pos_next   = r_pos + 1'b1;
        finish     = active && (pos_next >= sps_sat);
        slot_full  = r_sec_count - 11'd1 - r_sec_num;
        emit       = finish && (slot_full < 11'(MAX_SECTORS));
        divisor    = DW'({valid_next, 3'b000}) + DW'({valid_next, 1'b0});
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;

    // Counter update on each accepted sample while active; scan end clears after it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum     <= '0;
            r_valid   <= '0;
            r_pos     <= '0;
            r_sec_num <= '0;
        end else if (s_accept) begin
            if (i_s_tlast) begin
                r_sum     <= '0;
                r_valid   <= '0;
                r_pos     <= '0;
                r_sec_num <= '0;
            end else if (active) begin
                if (finish) begin
                    r_sum     <= '0;
                    r_valid   <= '0;
                    r_pos     <= '0;
                    r_sec_num <= r_sec_num + 11'd1;
                end else begin
                    r_sum   <= sum_next;
                    r_valid <= valid_next;
                    r_pos   <= pos_next;
                end
            end
        end
    end

    // Side data of the sector under division.
    always_ff @(posedge i_clk) begin
        if (s_accept && emit) begin
            r_empty <= (valid_next == '0);
            r_slot  <= slot_full[SW-1:0];
            r_final <= (r_sec_num + 11'd1 == r_sec_count);
        end
    end

    // Average: sector sum divided by ten times the valid count.
    lsrd_div #(
        .NW (SUMW),
        .DW (DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (s_accept && emit),
        .i_dividend (sum_next),
        .i_divisor  (divisor),
        .o_status   (div_status),
        .o_quotient (quotient)
    );

    // Classification of the average against the centimeter window.
    always_comb begin
        cm_value = r_empty ? SUMW'(r_max_cm) : quotient;
        has      = 1'b0;
        if (cm_value >= SUMW'(r_max_cm)) begin
            cm_out = 16'(r_max_cm) + 16'd1;
        end else if (cm_value < SUMW'(r_min_cm)) begin
            cm_out = 16'd0;
        end else begin
            cm_out = cm_value[15:0];
            has    = 1'b1;
        end
    end

    assign can_load = !r_m_valid || i_m_tready;

    // Controller: next state and output load.
    always_comb begin
        n_state  = r_state;
        load_out = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (s_accept && emit) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_status.done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (can_load) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (load_out) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_m_slot  <= r_slot;
            r_m_dist  <= cm_out;
            r_m_has   <= has;
            r_m_final <= r_final;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = OTDW'({r_m_dist, r_m_slot});
    assign o_m_tuser  = r_m_has;
    assign o_m_tlast  = r_m_final;

endmodule

// ----- design/lsrd_div.sv -----
module lsrd_div #(
    parameter int NW = 22,
    parameter int DW = 10
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [NW-1:0]              i_dividend,
    input  logic [DW-1:0]              i_divisor,
    output lsrd_pkg::t_div_status      o_status,
    output logic [NW-1:0]              o_quotient
);
    import lsrd_pkg::*;

    localparam int CW = (NW > 1) ? $clog2(NW) : 1;

    logic [NW-1:0] r_num;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [DW:0]   shifted;
    logic [DW:0]   diff;
    logic          q_bit;
    logic [DW-1:0] n_rem;

    // One restoring step: bring down the next dividend bit and try a subtract.
    always_comb begin
        shifted = {r_rem, r_num[NW-1]};
        diff    = shifted - {1'b0, r_den};
        q_bit   = (shifted >= {1'b0, r_den});
        n_rem   = q_bit ? diff[DW-1:0] : shifted[DW-1:0];
    end

    // Control: the run takes one step per dividend bit and ends with a one-cycle done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: the dividend shifts out at the top while quotient bits enter below.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_num <= {r_num[NW-2:0], q_bit};
            r_rem <= n_rem;
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quotient    = r_num;

endmodule
